@@ rtl/sfr_pkg.sv @@
`timescale 1ns / 1ps

package sfr_pkg;

   // Field widths fixed by the frame format
   localparam int DATA_W     = 8;
   localparam int INDEX_W    = 7;
   localparam int LEN_W      = 8;
   localparam int LPOS_W     = 7;
   localparam int TARGET_W   = 10;
   localparam int CSR_ADDR_W = 3;

   // Command codes on the request channel
   localparam logic CMD_ARM  = 1'b0;
   localparam logic CMD_BYTE = 1'b1;

   // Register map of the configuration port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_EXPECTED_COUNT  = 3'd0,
      CSR_START_CHAR      = 3'd1,
      CSR_STOP_CHAR       = 3'd2,
      CSR_ECHO_ENABLE     = 3'd3,
      CSR_LENGTH_POSITION = 3'd4,
      CSR_LENGTH_ADJUST   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0]        expected_count;
      logic [DATA_W-1:0]        start_char;
      logic [DATA_W-1:0]        stop_char;
      logic                     echo_enable;
      logic [LPOS_W-1:0]        length_position;
      logic signed [DATA_W-1:0] length_adjust;
   } cfg_type;

   typedef struct packed {
      logic              command;
      logic [DATA_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic               echo_valid;
      logic [DATA_W-1:0]  echo_byte;
      logic               store_valid;
      logic [INDEX_W-1:0] store_index;
      logic [DATA_W-1:0]  store_byte;
      logic               frame_done;
      logic [LEN_W-1:0]   frame_length;
      logic               overflow;
      logic               busy_res;
   } rsp_type;

endpackage

@@ rtl/sfr_if.sv @@
`timescale 1ns / 1ps

// Request channel: arm command or one received byte
interface sfr_req_if import sfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [DATA_W-1:0] rx_byte;

   modport source (output valid, command, rx_byte, input ready);
   modport sink   (input valid, command, rx_byte, output ready);
endinterface

// Result channel: one result per request
interface sfr_rsp_if import sfr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               echo_valid;
   logic [DATA_W-1:0]  echo_byte;
   logic               store_valid;
   logic [INDEX_W-1:0] store_index;
   logic [DATA_W-1:0]  store_byte;
   logic               frame_done;
   logic [LEN_W-1:0]   frame_length;
   logic               overflow;
   logic               busy_res;

   modport source (output valid, echo_valid, echo_byte, store_valid, store_index, store_byte,
                   frame_done, frame_length, overflow, busy_res, input ready);
   modport sink   (input valid, echo_valid, echo_byte, store_valid, store_index, store_byte,
                   frame_done, frame_length, overflow, busy_res, output ready);
endinterface

// Configuration write channel
interface sfr_csr_if import sfr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [DATA_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

@@ rtl/sfr_csr_regs.sv @@
`timescale 1ns / 1ps

module sfr_csr_regs import sfr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sfr_csr_if.sink   csr,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take a write; unknown indexes are dropped
   assign csr.ready = 1'b1;

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_EXPECTED_COUNT:  cfg_in.expected_count  = csr.wdata;
            CSR_START_CHAR:      cfg_in.start_char      = csr.wdata;
            CSR_STOP_CHAR:       cfg_in.stop_char       = csr.wdata;
            CSR_ECHO_ENABLE:     cfg_in.echo_enable     = csr.wdata[0];
            CSR_LENGTH_POSITION: cfg_in.length_position = csr.wdata[LPOS_W-1:0];
            CSR_LENGTH_ADJUST:   cfg_in.length_adjust   = $signed(csr.wdata);
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/sfr_deframer.sv @@
`timescale 1ns / 1ps

module sfr_deframer import sfr_pkg::*; #(
   parameter int BUFFER_SIZE = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int POS_W = $clog2(BUFFER_SIZE);
   localparam logic [POS_W:0]           COUNT_LIMIT  = (POS_W + 1)'(BUFFER_SIZE);
   localparam logic signed [TARGET_W:0] TARGET_LIMIT = (TARGET_W + 1)'(BUFFER_SIZE);

   logic                idle_ff, idle_in;
   logic                in_frame_ff, in_frame_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [TARGET_W-1:0] target_ff, target_in;

   logic                found_start;
   logic                len_hit;
   logic                stop_hit;
   logic [POS_W:0]      count;
   logic [TARGET_W-1:0] len_sum;
   logic [TARGET_W-1:0] target_cur;
   logic                too_long;
   logic                count_hit;
   logic                full;

   // Per-byte arithmetic shared by the decision logic below
   assign count    = (POS_W + 1)'(pos_ff) + (POS_W + 1)'(1);
   assign len_hit  = (cfg.length_position != '0) &&
                     (DATA_W'(pos_ff) == DATA_W'(cfg.length_position));
   assign len_sum  = TARGET_W'($signed({2'b00, item.rx_byte}) +
                               $signed({{2{cfg.length_adjust[DATA_W-1]}}, cfg.length_adjust}));
   assign target_cur = len_hit ? len_sum : target_ff;
   assign too_long   = $signed({target_cur[TARGET_W-1], target_cur}) >= TARGET_LIMIT;
   assign count_hit  = target_cur == TARGET_W'(count);
   assign full       = count >= COUNT_LIMIT;
   assign found_start = !in_frame_ff && (item.rx_byte == cfg.start_char);
   assign stop_hit   = (cfg.stop_char != '0) && (item.rx_byte == cfg.stop_char) && !found_start;

   // Next state and result for the item in the input register
   always_comb begin
      result      = '0;
      idle_in     = idle_ff;
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      target_in   = target_ff;
      if (item.command == CMD_ARM) begin
         if (idle_ff) begin
            target_in   = TARGET_W'(cfg.expected_count);
            in_frame_in = (cfg.start_char == '0) && (cfg.stop_char == '0);
            pos_in      = '0;
            idle_in     = 1'b0;
         end
      end else if (!idle_ff) begin
         // Hunting: echo skipped bytes
         if (!in_frame_ff && !found_start && cfg.echo_enable) begin
            result.echo_valid = 1'b1;
            result.echo_byte  = item.rx_byte;
         end
         if (in_frame_ff || found_start) begin
            result.store_valid = 1'b1;
            result.store_index = INDEX_W'(pos_ff);
            result.store_byte  = item.rx_byte;
            if (cfg.echo_enable) begin
               result.echo_valid = 1'b1;
               result.echo_byte  = item.rx_byte;
            end
            target_in   = target_cur;
            in_frame_in = 1'b1;
            if (too_long || count_hit || stop_hit || full) begin
               result.frame_done   = 1'b1;
               result.frame_length = LEN_W'(count);
               result.overflow     = too_long || (!count_hit && !stop_hit);
               in_frame_in         = 1'b0;
               idle_in             = 1'b1;
               pos_in              = '0;
            end else begin
               pos_in = POS_W'(count);
            end
         end
      end
      result.busy_res = !idle_in;
   end

   // Advance frame state once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff     <= 1'b1;
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         target_ff   <= '0;
      end else if (step_en) begin
         idle_ff     <= idle_in;
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         target_ff   <= target_in;
      end
   end

endmodule

@@ rtl/serial_frame_receiver.sv @@
`timescale 1ns / 1ps

// Serial frame receiver. Each request is either an arm command or one received byte, and each
// request yields exactly one result telling whether to echo the byte, where to store it in the
// frame buffer, and whether it closed the frame (with its length and an overflow flag). A request
// is registered on entry, decoded against the frame state and lands in the result register, so
// the block takes one request per clock while the result channel is not stalled; a stalled
// result holds back only the input register. Configuration registers take effect on the next
// request and are to be written while no frame work is pending; the block does not enforce this.
module serial_frame_receiver import sfr_pkg::*; #(
   parameter int BUFFER_SIZE = 128
) (
   input  logic       clock,
   input  logic       reset,
   sfr_req_if.sink    req_bus,
   sfr_rsp_if.source  rsp_bus,
   sfr_csr_if.sink    csr_bus
);

   cfg_type cfg;
   req_type in_data_ff, in_data_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    out_valid_ff, out_valid_in;
   logic    advance;
   logic    req_take;

   sfr_csr_regs u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   sfr_deframer #(.BUFFER_SIZE(BUFFER_SIZE)) u_deframer (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (out_data_in)
   );

   // Move the input item into the result register when that slot frees up
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_data_in   = in_data_ff;
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (req_take) begin
         in_data_in.command = req_bus.command;
         in_data_in.rx_byte = req_bus.rx_byte;
         in_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // Drive the result channel
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.echo_valid   = out_data_ff.echo_valid;
   assign rsp_bus.echo_byte    = out_data_ff.echo_byte;
   assign rsp_bus.store_valid  = out_data_ff.store_valid;
   assign rsp_bus.store_index  = out_data_ff.store_index;
   assign rsp_bus.store_byte   = out_data_ff.store_byte;
   assign rsp_bus.frame_done   = out_data_ff.frame_done;
   assign rsp_bus.frame_length = out_data_ff.frame_length;
   assign rsp_bus.overflow     = out_data_ff.overflow;
   assign rsp_bus.busy_res     = out_data_ff.busy_res;

   // A closed frame leaves the block idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.frame_done |-> !rsp_bus.busy_res)
      else $error("frame closed while still reporting busy");

   // Overflow only comes with a closing byte that was stored
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.overflow |-> rsp_bus.frame_done && rsp_bus.store_valid)
      else $error("overflow without a stored closing byte");

   // A held input item stays in place until it moves on
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input item lost while the result side stalled");

   // The input slot empties only by moving into the result register
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !req_take |=> in_valid_ff || out_valid_ff)
      else $error("input item dropped without a result");

endmodule
